// ----- hdl/assert_macros.svh -----
// Assertion helpers for the exponentiation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert an implication on every clock outside reset
`define CHK_IMPL(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assert a property that must also hold during reset
`define CHK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- hdl/modexp_pkg.sv -----
package modexp_pkg;
   localparam int OPERAND_WIDTH = 32;
   localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);

   localparam logic CMD_POWER   = 1'b0;
   localparam logic CMD_INVERSE = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture operands
      logic red_base;   // one restoring step of base %= mod
      logic mul_init;   // start a modular multiply
      logic mul_step;   // one shift-add step
      logic mul_sq;     // 1: square base, 0: acc *= base
      logic mul_done;   // write back product
      logic exp_shift;  // drop exponent lsb
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mod_zero;
      logic exp_zero;
      logic exp_lsb;
      logic red_last;
      logic mul_last;
   } dp_sts_type;
endpackage

// ----- hdl/modexp_datapath.sv -----
module modexp_datapath (
   input  logic                                 clock,
   input  logic                                 req_cmd,
   input  logic [modexp_pkg::OPERAND_WIDTH-1:0] req_base_value,
   input  logic [modexp_pkg::OPERAND_WIDTH-1:0] req_exponent_value,
   input  logic [modexp_pkg::OPERAND_WIDTH-1:0] req_modulus_value,
   input  modexp_pkg::dp_cmd_type               cmd,
   output modexp_pkg::dp_sts_type               sts,
   output logic [modexp_pkg::OPERAND_WIDTH-1:0] acc_value
);
   localparam int W = modexp_pkg::OPERAND_WIDTH;
   localparam int CW = modexp_pkg::CNT_W;

   logic [W-1:0] mod_ff, base_ff, exp_ff, acc_ff, x_ff, y_ff, p_ff;
   logic [W-1:0] mod_in, base_in, exp_in, acc_in, x_in, y_in, p_in;
   logic [W:0]   rem_ff, rem_in;          // partial remainder for base reduction
   logic [CW-1:0] cnt_ff, cnt_in;

   // (a + b) mod m for a, b < m
   function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, b, m);
      logic [W-1:0] gap;
      gap = m - b;
      return (a >= gap) ? a - gap : a + b;
   endfunction

   logic [W:0] rem_sh;
   always_comb begin
      mod_in = mod_ff; base_in = base_ff; exp_in = exp_ff; acc_in = acc_ff;
      x_in = x_ff; y_in = y_ff; p_in = p_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      rem_sh = {rem_ff[W-1:0], base_ff[W-1]};
      if (cmd.load) begin
         mod_in = req_modulus_value;
         base_in = req_base_value;
         acc_in = {{(W-1){1'b0}}, 1'b1};
         rem_in = '0;
         cnt_in = '0;
         if (req_cmd == modexp_pkg::CMD_INVERSE)
            exp_in = (req_modulus_value < W'(2)) ? '0 : req_modulus_value - W'(2);
         else
            exp_in = req_exponent_value;
      end
      if (cmd.red_base) begin
         // restoring division: shift a base bit into the remainder
         if (rem_sh >= {1'b0, mod_ff}) rem_in = rem_sh - {1'b0, mod_ff};
         else rem_in = rem_sh;
         base_in = {base_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) base_in = rem_in[W-1:0];
      end
      if (cmd.mul_init) begin
         x_in = base_ff;
         y_in = cmd.mul_sq ? base_ff : acc_ff;
         p_in = '0;
         cnt_in = '0;
      end
      if (cmd.mul_step) begin
         if (y_ff[0]) p_in = add_mod(p_ff, x_ff, mod_ff);
         x_in = add_mod(x_ff, x_ff, mod_ff);
         y_in = y_ff >> 1;
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.mul_done) begin
         if (cmd.mul_sq) base_in = p_ff;
         else acc_in = p_ff;
      end
      if (cmd.exp_shift) exp_in = exp_ff >> 1;
   end

   always_ff @(posedge clock) begin
      mod_ff <= mod_in; base_ff <= base_in; exp_ff <= exp_in; acc_ff <= acc_in;
      x_ff <= x_in; y_ff <= y_in; p_ff <= p_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
   end

   assign sts.mod_zero = (mod_ff == '0);
   assign sts.exp_zero = (exp_ff == '0);
   assign sts.exp_lsb  = exp_ff[0];
   assign sts.red_last = (cnt_ff == CW'(W - 1));
   // multiply ends once the multiplier runs out of ones
   assign sts.mul_last = (y_ff == '0);
   assign acc_value = acc_ff;
endmodule

// ----- hdl/modexp_control.sv -----
module modexp_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  modexp_pkg::dp_sts_type sts,
   output modexp_pkg::dp_cmd_type cmd,
   output logic                   done,
   output logic                   err
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_RED   = 7'b0000100,
      S_LOOP  = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_SQ    = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic sq_ff, sq_in, init_ff, init_in, err_ff, err_in;

   always_comb begin
      state_in = state_ff; sq_in = sq_ff; init_in = init_ff; err_in = err_ff;
      cmd = '0;
      cmd.mul_sq = sq_ff;
      done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            err_in = sts.mod_zero;
            state_in = sts.mod_zero ? S_OUT : S_RED;
         end
         S_RED: begin
            cmd.red_base = 1'b1;
            if (sts.red_last) state_in = S_LOOP;
         end
         S_LOOP: begin
            if (sts.exp_zero) state_in = S_OUT;
            else begin
               cmd.mul_init = 1'b1;
               cmd.mul_sq = ~sts.exp_lsb;
               sq_in = ~sts.exp_lsb;
               state_in = sts.exp_lsb ? S_MUL : S_SQ;
            end
         end
         S_MUL, S_SQ: begin
            if (init_ff) begin
               // square setup after a multiply has written acc
               cmd.mul_init = 1'b1;
               init_in = 1'b0;
            end else if (sts.mul_last) begin
               cmd.mul_done = 1'b1;
               if (state_ff == S_MUL) begin
                  sq_in = 1'b1;
                  init_in = 1'b1;
                  state_in = S_SQ;
               end else begin
                  cmd.exp_shift = 1'b1;
                  state_in = S_LOOP;
               end
            end else cmd.mul_step = 1'b1;
         end
         S_OUT: begin
            done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sq_ff <= 1'b0; init_ff <= 1'b0; err_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sq_ff <= sq_in; init_ff <= init_in; err_ff <= err_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign err = err_ff;
endmodule

// ----- hdl/modular_exponentiation.sv -----
// Channel   | Handshake              | Payload
// request   | start & !busy          | req_cmd, req_base_value, req_exponent_value,
//           |                        | req_modulus_value
// response  | rsp_valid (one cycle)  | rsp_result_value, rsp_error_flag
//
// One word at a time; busy is high from the edge after accept through the strobe.
// Busy phases: a check, WIDTH base reduction steps, then per exponent bit a loop
// state, for a set bit a multiply and a square setup, and then a square; after
// that a final loop state and the output. A zero modulus goes from the check
// straight to the output.
// Synchronous reset returns the controller to idle; the receiver cannot stall.
module modular_exponentiation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic [modexp_pkg::OPERAND_WIDTH-1:0] req_base_value,
   input  logic [modexp_pkg::OPERAND_WIDTH-1:0] req_exponent_value,
   input  logic [modexp_pkg::OPERAND_WIDTH-1:0] req_modulus_value,
   output logic                                 rsp_valid,
   output logic [modexp_pkg::OPERAND_WIDTH-1:0] rsp_result_value,
   output logic                                 rsp_error_flag
);
   modexp_pkg::dp_cmd_type cmd;
   modexp_pkg::dp_sts_type sts;
   logic [modexp_pkg::OPERAND_WIDTH-1:0] acc_value;
   logic done, err;

   modexp_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .sts(sts), .cmd(cmd), .done(done), .err(err)
   );

   modexp_datapath u_dp (
      .clock(clock), .req_cmd(req_cmd), .req_base_value(req_base_value),
      .req_exponent_value(req_exponent_value), .req_modulus_value(req_modulus_value),
      .cmd(cmd), .sts(sts), .acc_value(acc_value)
   );

   // zero modulus forces a zero result with the error flag
   assign rsp_valid        = done;
   assign rsp_error_flag   = err;
   assign rsp_result_value = err ? '0 : acc_value;
endmodule

// ----- hdl/modexp_checker.sv -----
`include "assert_macros.svh"
module modexp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic [modexp_pkg::OPERAND_WIDTH-1:0] rsp_result_value,
   input logic                                 rsp_error_flag
);
   `CHK_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_error_flag |-> rsp_result_value == '0, "error result not zero")
   `CHK_IMPL(a_one_strobe, clock, reset, rsp_valid |=> !rsp_valid, "strobe longer than one cycle")
   `CHK_IMPL(a_accept_busy, clock, reset, start && !busy |=> busy, "not busy after accept")
   `CHK_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid, "not idle after reset")
endmodule

bind modular_exponentiation modexp_checker u_chk (.*);

// ----- verif/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = modexp_pkg::OPERAND_WIDTH;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic         cmd;
      logic [W-1:0] base_v;
      logic [W-1:0] exp_v;
      logic [W-1:0] mod_v;
   } op_word_type;

   typedef struct {
      logic [W-1:0] result_v;
      logic         err;
   } pow_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic         req_cmd = 1'b0;
   logic [W-1:0] req_base_value = '0;
   logic [W-1:0] req_exponent_value = '0;
   logic [W-1:0] req_modulus_value = '0;
   logic         rsp_valid;
   logic [W-1:0] rsp_result_value;
   logic         rsp_error_flag;

   op_word_type  op_queue[$];     // words waiting to be issued
   pow_word_type expected_pows[$]; // predicted results in issue order
   int        mismatches = 0;
   int        idle_pct = 0;    // sender idle chance, percent
   longint    cycle_cnt = 0;

   modular_exponentiation u_top (.*);

   always #2 clock = ~clock;

   // (x*y) mod m using a double-width product; m nonzero
   function automatic logic [W-1:0] mulmod(logic [W-1:0] x, logic [W-1:0] y,
                                           logic [W-1:0] m);
      logic [2*W-1:0] p;
      p = {{W{1'b0}}, x} * {{W{1'b0}}, y};
      return W'(p % {{W{1'b0}}, m});
   endfunction

   // right-to-left square and multiply
   function automatic pow_word_type modpow(op_word_type w);
      pow_word_type r;
      logic [W-1:0] e, b, acc;
      r.err = 1'b0;
      if (w.mod_v == '0) begin
         r.result_v = '0;
         r.err = 1'b1;
         return r;
      end
      e = w.exp_v;
      if (w.cmd == modexp_pkg::CMD_INVERSE)
         e = (w.mod_v < W'(2)) ? '0 : w.mod_v - W'(2);
      acc = W'(1);
      b = w.base_v % w.mod_v;
      while (e != '0) begin
         if (e[0])
            acc = mulmod(acc, b, w.mod_v);
         b = mulmod(b, b, w.mod_v);
         e = e >> 1;
      end
      r.result_v = acc;
      return r;
   endfunction

   function automatic logic [W-1:0] rnd_w();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return W'($urandom_range(0, 3));
         3: return W'($urandom_range(0, 255));
         default: return W'($urandom);
      endcase
   endfunction

   task automatic add_op(logic c, logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
      op_word_type w;
      w.cmd = c;
      w.base_v = b;
      w.exp_v = e;
      w.mod_v = m;
      op_queue = {op_queue, w};
   endtask

   // driver: start held until the handshake completes
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (!reset) begin
         if (start && !busy) begin
            // accepted this edge: prediction goes in now
            expected_pows = {expected_pows, modpow(op_queue.pop_front())};
            if (op_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_cmd            <= op_queue[0].cmd;
               req_base_value     <= op_queue[0].base_v;
               req_exponent_value <= op_queue[0].exp_v;
               req_modulus_value  <= op_queue[0].mod_v;
            end else
               start <= 1'b0;
         end else if (!start && op_queue.size() > 0
                      && $urandom_range(0, 99) >= idle_pct) begin
            start              <= 1'b1;
            req_cmd            <= op_queue[0].cmd;
            req_base_value     <= op_queue[0].base_v;
            req_exponent_value <= op_queue[0].exp_v;
            req_modulus_value  <= op_queue[0].mod_v;
         end
      end
   end

   // monitor: compare each strobed word against the oldest prediction
   always @(posedge clock) begin
      pow_word_type exp_w;
      if (!reset && rsp_valid) begin
         if (expected_pows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h err %b", rsp_result_value, rsp_error_flag);
         end else begin
            exp_w = expected_pows.pop_front();
            if (exp_w.result_v !== rsp_result_value || exp_w.err !== rsp_error_flag) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result exp %h/%b got %h/%b", exp_w.result_v, exp_w.err,
                           rsp_result_value, rsp_error_flag);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("modular_exponentiation: mismatch");
         $finish;
      end
   end

   initial begin
      int phase;
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero modulus, zero exponent, modulus one, inverse corners,
      // unreduced base and all-ones extremes
      add_op(modexp_pkg::CMD_POWER, 5, 3, 0);
      add_op(modexp_pkg::CMD_INVERSE, '1, '1, 0);
      add_op(modexp_pkg::CMD_POWER, 7, 0, 1);
      add_op(modexp_pkg::CMD_POWER, 7, 0, 13);
      add_op(modexp_pkg::CMD_POWER, 7, 5, 1);
      add_op(modexp_pkg::CMD_INVERSE, 9, 4, 1);
      add_op(modexp_pkg::CMD_INVERSE, 3, 0, 2);
      add_op(modexp_pkg::CMD_INVERSE, 3, 8, 7);
      add_op(modexp_pkg::CMD_INVERSE, 14, 8, 7);
      add_op(modexp_pkg::CMD_INVERSE, 4, 1, 9);
      add_op(modexp_pkg::CMD_INVERSE, 5, 1, 32'hFFFF_FFFB);
      add_op(modexp_pkg::CMD_POWER, 100, 3, 7);
      add_op(modexp_pkg::CMD_POWER, '1, '1, '1);
      add_op(modexp_pkg::CMD_POWER, '1, '1, 32'hFFFF_FFFE);
      add_op(modexp_pkg::CMD_POWER, 0, 0, '1);
      add_op(modexp_pkg::CMD_POWER, 0, 9, '1);
      add_op(modexp_pkg::CMD_POWER, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
      add_op(modexp_pkg::CMD_POWER, 2, 31, '1);
      add_op(modexp_pkg::CMD_INVERSE, '1, 0, 32'hFFFF_FFFB);

      // random: three idling phases, sender idle 6%, then 58%, then none
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 6 : (phase == 1) ? 58 : 0;
         for (k = 0; k < 84; k++)
            add_op(1'($urandom_range(0, 1)), rnd_w(), rnd_w(),
                   ($urandom_range(0, 19) == 0) ? W'(0) : rnd_w());
         wait (op_queue.size() == 0);
      end
      wait (expected_pows.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("modular_exponentiation: match");
      else
         $display("modular_exponentiation: mismatch");
      $finish;
   end
endmodule
